// ===== src/rtcm2_pkg.sv =====
// Shared types and constants for the RTCM type-1 word decoder.
package rtcm2_pkg;

  localparam int unsigned StoreDepth = 32;
  localparam int unsigned AddrW      = 5;
  localparam int unsigned DataW      = 24;

  localparam logic [7:0] Preamble = 8'h66;

  localparam logic [DataW-1:0] ParMask [6] = '{
    24'hEC7CD2, 24'h763E69, 24'hBB1F34, 24'h5D8F9A, 24'hAEC7CD, 24'h2DEA27
  };
  // bit k set: prior D29 enters parity bit k, else prior D30
  localparam logic [5:0] ParUse29 = 6'b100101;

  typedef enum logic [3:0] {
    PhHunt = 4'b0001,
    PhHdr1 = 4'b0010,
    PhHdr2 = 4'b0100,
    PhBody = 4'b1000
  } phase_e;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [DataW-1:0] data;
  } wr_t;

  typedef struct packed {
    logic             valid;
    logic [AddrW-1:0] len;
    logic [12:0]      zcount;
  } start_t;

endpackage

// ===== src/rtcm2_framer.sv =====
// Byte framing, preamble hunt, parity check and body word write port.
module rtcm2_framer #(
  parameter int unsigned MAX_BODY_WORDS = 31
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            raw_byte_i,
  input  logic [5:0]            wanted_type_i,
  output rtcm2_pkg::wr_t        wr_o,
  output rtcm2_pkg::start_t     start_o
);

  rtcm2_pkg::phase_e phase_q, phase_d;
  logic [29:0] win_q, win_d;
  logic [2:0]  biw_q, biw_d;
  logic        d29_q, d29_d, d30_q, d30_d;
  logic [5:0]  htype_q, htype_d;
  logic [12:0] zc_q, zc_d;
  logic [4:0]  blen_q, blen_d;
  logic [4:0]  ws_q, ws_d;
  rtcm2_pkg::start_t start_q, start_d;

  logic [5:0]  rev;
  logic [7:0]  cmp;
  logic [23:0] data;
  logic [5:0]  par, calc;
  logic [2:0]  biw_inc;
  logic [4:0]  ws_inc;

  always_comb begin
    for (int i = 0; i < 6; i++) begin
      rev[5-i] = raw_byte_i[i];
    end
    win_d = {win_q[23:0], rev};
    cmp   = win_d[11:4] ^ {8{d30_q}};
    data  = win_d[29:6] ^ {24{d30_q}};
    par   = win_d[5:0];
    for (int k = 0; k < 6; k++) begin
      calc[5-k] = (^(data & rtcm2_pkg::ParMask[k])) ^
                  (rtcm2_pkg::ParUse29[k] ? d29_q : d30_q);
    end
    biw_inc = biw_q + 3'd1;
    ws_inc  = ws_q + 5'd1;
  end

  always_comb begin
    phase_d = phase_q;
    biw_d   = biw_q;
    d29_d   = d29_q;
    d30_d   = d30_q;
    htype_d = htype_q;
    zc_d    = zc_q;
    blen_d  = blen_q;
    ws_d    = ws_q;
    start_d = '0;
    wr_o    = '{en: 1'b0, addr: ws_q, data: data};
    if (accept_i) begin
      if (phase_q == rtcm2_pkg::PhHunt) begin
        if (biw_q != 3'd0 && cmp == rtcm2_pkg::Preamble) begin
          phase_d = rtcm2_pkg::PhHdr1;
          biw_d   = 3'd2;
        end else begin
          biw_d = 3'd1;
        end
      end else if (biw_inc < 3'd5) begin
        biw_d = biw_inc;
      end else begin
        biw_d = 3'd0;
        d29_d = par[1];
        d30_d = par[0];
        unique case (phase_q)
          rtcm2_pkg::PhHdr1: begin
            htype_d = data[15:10];
            phase_d = rtcm2_pkg::PhHdr2;
          end
          rtcm2_pkg::PhHdr2: begin
            if (calc != par) begin
              phase_d = rtcm2_pkg::PhHunt;
            end else begin
              zc_d   = data[23:11];
              blen_d = data[7:3];
              ws_d   = 5'd0;
              if (htype_q != wanted_type_i ||
                  32'(data[7:3]) > MAX_BODY_WORDS || data[7:3] == 5'd0) begin
                phase_d = rtcm2_pkg::PhHunt;
              end else begin
                phase_d = rtcm2_pkg::PhBody;
              end
            end
          end
          rtcm2_pkg::PhBody: begin
            if (calc != par) begin
              phase_d = rtcm2_pkg::PhHunt;
            end else begin
              wr_o.en = 1'b1;
              ws_d    = ws_inc;
              if (ws_inc == blen_q) begin
                phase_d = rtcm2_pkg::PhHunt;
                start_d = '{valid: 1'b1, len: blen_q, zcount: zc_q};
              end
            end
          end
          default: phase_d = rtcm2_pkg::PhHunt;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= rtcm2_pkg::PhHunt;
      win_q   <= '0;
      biw_q   <= '0;
      d29_q   <= 1'b1;
      d30_q   <= 1'b1;
      htype_q <= '0;
      zc_q    <= '0;
      blen_q  <= '0;
      ws_q    <= '0;
      start_q <= '0;
    end else begin
      if (accept_i) begin
        win_q <= win_d;
      end
      phase_q <= phase_d;
      biw_q   <= biw_d;
      d29_q   <= d29_d;
      d30_q   <= d30_d;
      htype_q <= htype_d;
      zc_q    <= zc_d;
      blen_q  <= blen_d;
      ws_q    <= ws_d;
      start_q <= start_d;
    end
  end

  assign start_o = start_q;

endmodule

// ===== src/rtcm2_emit.sv =====
// Body word store and satellite record unpacker with output register.
module rtcm2_emit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  rtcm2_pkg::wr_t       wr_i,
  input  rtcm2_pkg::start_t    start_i,
  output logic                 busy_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [5:0]           sat_prn_o,
  output logic [12:0]          z_count_o,
  output logic signed [15:0]   range_correction_o,
  output logic signed [7:0]    rate_correction_o,
  output logic                 scale_large_o,
  output logic [7:0]           data_issue_o,
  output logic                 last_record_o
);

  logic [rtcm2_pkg::DataW-1:0] mem [rtcm2_pkg::StoreDepth];
  logic [rtcm2_pkg::DataW-1:0] rd_data_q;

  logic        active_q, pend_q;
  logic [4:0]  addr_q, left_q;
  logic [63:0] buf_q;
  logic [6:0]  cnt_q;
  logic [12:0] zc_q;
  logic        rd_en, pop, out_free, done;
  logic [9:0]  remain;
  logic [4:0]  id;

  assign out_free = !out_valid_o || !out_stall_i;
  assign rd_en    = active_q && !pend_q && cnt_q < 7'd40 && left_q != 5'd0;
  assign pop      = active_q && !pend_q && cnt_q >= 7'd40 && out_free;
  assign done     = active_q && !pend_q && cnt_q < 7'd40 && left_q == 5'd0;
  assign remain   = 10'(cnt_q - 7'd40) + {1'b0, left_q, 4'b0} + {2'b0, left_q, 3'b0};
  assign id       = buf_q[60:56];
  assign busy_o   = active_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en) begin
      rd_data_q <= mem[addr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      pend_q   <= 1'b0;
      addr_q   <= '0;
      left_q   <= '0;
      cnt_q    <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (start_i.valid) begin
        active_q <= 1'b1;
        pend_q   <= 1'b0;
        addr_q   <= '0;
        left_q   <= start_i.len;
        cnt_q    <= '0;
      end else begin
        if (done) begin
          active_q <= 1'b0;
        end
        if (rd_en) begin
          pend_q <= 1'b1;
          addr_q <= addr_q + 5'd1;
          left_q <= left_q - 5'd1;
        end
        if (pend_q) begin
          pend_q <= 1'b0;
          cnt_q  <= cnt_q + 7'd24;
        end
        if (pop) begin
          cnt_q <= cnt_q - 7'd40;
        end
      end
      if (pop) begin
        out_valid_o <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i.valid) begin
      buf_q <= '0;
      zc_q  <= start_i.zcount;
    end else if (pend_q) begin
      buf_q <= buf_q | ({rd_data_q, 40'b0} >> cnt_q);
    end else if (pop) begin
      buf_q <= buf_q << 40;
    end
    if (pop) begin
      sat_prn_o          <= (id == 5'd0) ? 6'd32 : {1'b0, id};
      z_count_o          <= zc_q;
      range_correction_o <= buf_q[55:40];
      rate_correction_o  <= buf_q[39:32];
      scale_large_o      <= buf_q[63];
      data_issue_o       <= buf_q[31:24];
      last_record_o      <= remain < 10'd40;
    end
  end

endmodule

// ===== src/rtcm2_type1_word_decoder.sv =====
// Top level of the RTCM type-1 word decoder.
// Usage:
//   Input channel: one link byte per transaction on raw_byte_i, qualified by
//   in_valid_i and held off by in_stall_o. Each accepted byte is shifted into
//   the word window on the edge that accepts it; framing, parity and header
//   checks complete on the edge that accepts the fifth byte of a word.
//   When the last body word of a message of the configured type passes,
//   the body store is unpacked: each body word is read from memory, then
//   merged into the unpack buffer, and a record is emitted each time the
//   buffer holds a full record. During this burst in_stall_o is high.
//   Output channel: one satellite record per transaction on the *_o fields,
//   qualified by out_valid_o; while out_stall_i is high the record holds and
//   unpacking pauses, stretching the burst.
//   Configuration: cfg_we_i writes cfg_wdata_i as the wanted message type.
//   Reset: preamble hunting, message type 1, no record pending. The body
//   store needs no clearing.
module rtcm2_type1_word_decoder #(
  parameter int unsigned MAX_BODY_WORDS = 31
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [5:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [7:0]          raw_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [5:0]          sat_prn_o,
  output logic [12:0]         z_count_o,
  output logic signed [15:0]  range_correction_o,
  output logic signed [7:0]   rate_correction_o,
  output logic                scale_large_o,
  output logic [7:0]          data_issue_o,
  output logic                last_record_o
);

  logic [5:0]         wanted_q;
  rtcm2_pkg::wr_t     wr;
  rtcm2_pkg::start_t  start;
  logic               busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q <= 6'd1;
    end else if (cfg_we_i) begin
      wanted_q <= cfg_wdata_i;
    end
  end

  assign in_stall_o = busy || start.valid;

  rtcm2_framer #(
    .MAX_BODY_WORDS(MAX_BODY_WORDS)
  ) u_framer (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (in_valid_i && !in_stall_o),
    .raw_byte_i   (raw_byte_i),
    .wanted_type_i(wanted_q),
    .wr_o         (wr),
    .start_o      (start)
  );

  rtcm2_emit u_emit (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .wr_i              (wr),
    .start_i           (start),
    .busy_o            (busy),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .sat_prn_o         (sat_prn_o),
    .z_count_o         (z_count_o),
    .range_correction_o(range_correction_o),
    .rate_correction_o (rate_correction_o),
    .scale_large_o     (scale_large_o),
    .data_issue_o      (data_issue_o),
    .last_record_o     (last_record_o)
  );

endmodule
